### sv/tlsd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tlsd_pkg
// Shared types and constants for the tagged LRU slot directory.
// ============================================================================
package tlsd_pkg;

   // Default number of directory slots
   localparam int SLOTS_DEF = 8;

   // Fixed field widths
   localparam int KEY_W      = 32;
   localparam int SLOT_OUT_W = 3;

   // Request transaction payload
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             fill_ok;
   } tlsd_req_type;

   // Response transaction payload
   typedef struct packed {
      logic [SLOT_OUT_W-1:0] slot;
      logic                  hit;
      logic                  fill_failed;
   } tlsd_rsp_type;

   // Finished lookup handed from the sequencer to the output register
   typedef struct packed {
      logic         valid;
      tlsd_rsp_type rsp;
   } tlsd_res_type;

endpackage

### sv/tlsd_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// tlsd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module tlsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/tlsd_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// tlsd_seq
// Lookup sequencer: walks the tag RAM and the recency ring RAM one entry per
// cycle through a single shared equality comparator.
// ============================================================================
module tlsd_seq
   import tlsd_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  tlsd_req_type req_data,
   input  logic         res_ready,
   output tlsd_res_type res
);

   localparam int SW = $clog2(SLOTS);
   localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_SCAN      = 7'b0000010,
      S_VREAD     = 7'b0000100,
      S_VSEL      = 7'b0001000,
      S_TOUCH     = 7'b0010000,
      S_TOUCH_END = 7'b0100000,
      S_DONE      = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic                 fill_ok_ff, fill_ok_in;
   logic [SW-1:0]        cnt_ff, cnt_in;
   logic [SW-1:0]        rpos_ff, rpos_in;
   logic                 pend_ff, pend_in;
   logic [SW-1:0]        pend_idx_ff, pend_idx_in;
   logic                 pend_last_ff, pend_last_in;
   logic                 found_ff, found_in;
   logic [SW-1:0]        prev_pos_ff, prev_pos_in;
   logic [SW-1:0]        head_ff, head_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic                 hit_ff, hit_in;
   logic                 failed_ff, failed_in;
   logic [SLOTS-1:0]     tag_vld_ff, tag_vld_in;
   logic [SLOTS-1:0]     ring_vld_ff, ring_vld_in;

   // RAM ports
   logic                 tag_we, tag_re;
   logic [SW-1:0]        tag_waddr, tag_raddr;
   logic [KEY_W-1:0]     tag_rdata;
   logic                 ring_we, ring_re;
   logic [SW-1:0]        ring_waddr, ring_raddr, ring_wdata, ring_rdata;

   // Entry values with reset defaults for never-written entries
   logic [KEY_W-1:0]     tag_val;
   logic [SW-1:0]        ring_val;

   // Shared comparator
   logic [KEY_W-1:0]     cmp_a, cmp_b;
   logic                 cmp_eq;

   tlsd_ram #(
      .WIDTH(KEY_W),
      .DEPTH(SLOTS)
   ) u_tag_ram (
      .clock  (clock),
      .wr_en  (tag_we),
      .wr_addr(tag_waddr),
      .wr_data(key_ff),
      .rd_en  (tag_re),
      .rd_addr(tag_raddr),
      .rd_data(tag_rdata)
   );

   tlsd_ram #(
      .WIDTH(SW),
      .DEPTH(SLOTS)
   ) u_ring_ram (
      .clock  (clock),
      .wr_en  (ring_we),
      .wr_addr(ring_waddr),
      .wr_data(ring_wdata),
      .rd_en  (ring_re),
      .rd_addr(ring_raddr),
      .rd_data(ring_rdata)
   );

   // Unwritten tags read as zero, unwritten ring entries as their own index
   assign tag_val  = tag_vld_ff[pend_idx_ff] ? tag_rdata : '0;
   assign ring_val = ring_vld_ff[pend_idx_ff] ? ring_rdata : pend_idx_ff;

   // Share one comparator between the tag scan and the ring search
   always_comb begin
      if (state_ff == S_SCAN) begin
         cmp_a = key_ff;
         cmp_b = tag_val;
      end else begin
         cmp_a = KEY_W'(slot_ff);
         cmp_b = KEY_W'(ring_val);
      end
   end

   assign cmp_eq = (cmp_a == cmp_b);

   assign req_stall = (state_ff != S_IDLE);

   // Sequencer next-state logic
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      fill_ok_in   = fill_ok_ff;
      cnt_in       = cnt_ff;
      rpos_in      = rpos_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      pend_last_in = pend_last_ff;
      found_in     = found_ff;
      prev_pos_in  = prev_pos_ff;
      head_in      = head_ff;
      slot_in      = slot_ff;
      hit_in       = hit_ff;
      failed_in    = failed_ff;
      tag_vld_in   = tag_vld_ff;
      ring_vld_in  = ring_vld_ff;
      tag_we       = 1'b0;
      tag_waddr    = slot_ff;
      tag_re       = 1'b0;
      tag_raddr    = cnt_ff;
      ring_we      = 1'b0;
      ring_waddr   = prev_pos_ff;
      ring_wdata   = ring_val;
      ring_re      = 1'b0;
      ring_raddr   = rpos_ff;
      res.valid    = 1'b0;
      res.rsp.slot        = SLOT_OUT_W'(slot_ff);
      res.rsp.hit         = hit_ff;
      res.rsp.fill_failed = failed_ff;

      case (state_ff)
         // Take a new transaction and start the tag scan at slot 0
         S_IDLE: begin
            if (req_valid) begin
               key_in     = req_data.key;
               fill_ok_in = req_data.fill_ok;
               cnt_in     = '0;
               pend_in    = 1'b0;
               state_in   = S_SCAN;
            end
         end

         // Issue one tag read per cycle, compare the previous one
         S_SCAN: begin
            tag_re       = 1'b1;
            tag_raddr    = cnt_ff;
            pend_in      = 1'b1;
            pend_idx_in  = cnt_ff;
            pend_last_in = (cnt_ff == LAST);
            cnt_in       = (cnt_ff == LAST) ? cnt_ff : cnt_ff + 1'b1;
            if (pend_ff) begin
               if (cmp_eq) begin
                  hit_in    = 1'b1;
                  failed_in = 1'b0;
                  slot_in   = pend_idx_ff;
                  rpos_in   = head_ff;
                  cnt_in    = '0;
                  pend_in   = 1'b0;
                  found_in  = 1'b0;
                  state_in  = S_TOUCH;
               end else if (pend_last_ff) begin
                  hit_in   = 1'b0;
                  state_in = S_VREAD;
               end
            end
         end

         // Miss: fetch the least recent ring entry
         S_VREAD: begin
            ring_re     = 1'b1;
            ring_raddr  = head_ff;
            pend_idx_in = head_ff;
            state_in    = S_VSEL;
         end

         // Advance the head; fill the victim tag when the fill succeeded
         S_VSEL: begin
            head_in = (head_ff == LAST) ? '0 : head_ff + 1'b1;
            if (fill_ok_ff) begin
               tag_we                = 1'b1;
               tag_waddr             = ring_val;
               tag_vld_in[ring_val]  = 1'b1;
               slot_in               = ring_val;
               failed_in             = 1'b0;
            end else begin
               slot_in   = '0;
               failed_in = 1'b1;
            end
            state_in = S_DONE;
         end

         // Hit: walk the ring from the head, shift entries behind the hit slot
         S_TOUCH: begin
            ring_re      = 1'b1;
            ring_raddr   = rpos_ff;
            pend_in      = 1'b1;
            pend_idx_in  = rpos_ff;
            pend_last_in = (cnt_ff == LAST);
            rpos_in      = (rpos_ff == LAST) ? '0 : rpos_ff + 1'b1;
            cnt_in       = (cnt_ff == LAST) ? cnt_ff : cnt_ff + 1'b1;
            if (pend_ff) begin
               if (found_ff) begin
                  ring_we                  = 1'b1;
                  ring_waddr               = prev_pos_ff;
                  ring_wdata               = ring_val;
                  ring_vld_in[prev_pos_ff] = 1'b1;
               end
               found_in    = found_ff | cmp_eq;
               prev_pos_in = pend_idx_ff;
               if (pend_last_ff) begin
                  state_in = S_TOUCH_END;
               end
            end
         end

         // Place the hit slot at the most recent end
         S_TOUCH_END: begin
            ring_we                  = 1'b1;
            ring_waddr               = prev_pos_ff;
            ring_wdata               = slot_ff;
            ring_vld_in[prev_pos_ff] = 1'b1;
            state_in                 = S_DONE;
         end

         // Hand the result over once the output register is free
         S_DONE: begin
            if (res_ready) begin
               res.valid = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pend_ff     <= 1'b0;
         head_ff     <= '0;
         tag_vld_ff  <= '0;
         ring_vld_ff <= '0;
      end else begin
         state_ff    <= state_in;
         pend_ff     <= pend_in;
         head_ff     <= head_in;
         tag_vld_ff  <= tag_vld_in;
         ring_vld_ff <= ring_vld_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      fill_ok_ff   <= fill_ok_in;
      cnt_ff       <= cnt_in;
      rpos_ff      <= rpos_in;
      pend_idx_ff  <= pend_idx_in;
      pend_last_ff <= pend_last_in;
      found_ff     <= found_in;
      prev_pos_ff  <= prev_pos_in;
      slot_ff      <= slot_in;
      hit_ff       <= hit_in;
      failed_ff    <= failed_in;
   end

endmodule

### sv/tagged_lru_slot_directory_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tagged_lru_slot_directory_unit
// Fully associative slot directory with true LRU replacement.
//
//   Channel   Direction  Ports                         Payload
//   request   in         req_valid/req_stall/req_data  tlsd_req_type
//   response  out        rsp_valid/rsp_stall/rsp_data  tlsd_rsp_type
//
// A miss scans every tag RAM entry, then reads the least recent ring entry;
// a hit on slot m scans tags up to m, then walks the whole ring RAM, one
// entry per cycle through one comparator. The next request is taken once
// the sequencer is idle again. Reset clears the valid bits at once, so no
// clearing pass is needed. A stalled response holds in the output register
// while the next request is already accepted and processed.
// ============================================================================
module tagged_lru_slot_directory_unit
   import tlsd_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  tlsd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output tlsd_rsp_type rsp_data
);

   tlsd_res_type res;
   logic         res_ready;
   logic         rsp_valid_ff, rsp_valid_in;
   tlsd_rsp_type rsp_data_ff, rsp_data_in;

   tlsd_seq #(
      .SLOTS(SLOTS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .res_ready(res_ready),
      .res      (res)
   );

   // Output register is free when empty or being drained
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   // Load a finished transaction, drop a delivered one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
